>>> sv/uoi_pkg.sv
// Shared constants, types and tables of the unicycle odometry integrator.
package uoi_pkg;

	// Micro-rotations in the rotation chain (8 to 32).
	localparam int CORDIC_STAGES = 16;

	// Datapath widths.
	localparam int CW         = 34;	// x, y and residual angle inside the chain
	localparam int ATAN_DEPTH = 32;
	localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);
	localparam int ADDR_W     = 3;	// one register word plus a word beyond it

	// Register indexes on the configuration port.
	localparam logic [ADDR_W-3:0] REG_TIME_STEP = '0;

	localparam logic [15:0] TIME_STEP_RESET = 16'd6554;	// about 0.1 s in Q0.16

	// CORDIC gain compensation 0.60725 in Q2.30.
	localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

	// round(2^24 / (2 pi)): radians in Q8.24 to binary angle, scaled by 2^16.
	localparam logic signed [31:0] RAD_TO_BAM_Q16 = 32'sd2670177;

	// Arctangent of 2^-i in binary-angle units.
	localparam logic [31:0] ATAN_BAM [ATAN_DEPTH] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// One beat of the rotation chain.
	typedef struct packed {
		logic                 flip;	// half-turn folded away at entry
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_data_t;

endpackage

>>> sv/uoi_cell.sv
// One micro-rotation cell of the CORDIC chain.
module uoi_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [uoi_pkg::ATAN_IDX_W-1:0]     stage,
	input  logic                               in_valid,
	input  uoi_pkg::cordic_data_t              in_beat,
	output logic                               out_valid,
	output uoi_pkg::cordic_data_t              out_beat
);

	logic signed [uoi_pkg::CW-1:0] x_sh;
	logic signed [uoi_pkg::CW-1:0] y_sh;
	logic signed [uoi_pkg::CW-1:0] atan_d;
	uoi_pkg::cordic_data_t         next_d;

	always_comb begin
		x_sh   = in_beat.x >>> stage;
		y_sh   = in_beat.y >>> stage;
		atan_d = $signed({{(uoi_pkg::CW-32){1'b0}}, uoi_pkg::ATAN_BAM[stage]});
		next_d = in_beat;
		if (!in_beat.z[uoi_pkg::CW-1]) begin
			next_d.x = in_beat.x - y_sh;
			next_d.y = in_beat.y + x_sh;
			next_d.z = in_beat.z - atan_d;
		end else begin
			next_d.x = in_beat.x + y_sh;
			next_d.y = in_beat.y - x_sh;
			next_d.z = in_beat.z + atan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_beat <= next_d;
	end

endmodule

>>> sv/uoi_cordic.sv
// Rotation-mode CORDIC: quadrant fold followed by a chain of rotation cells.
module uoi_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [31:0]                   in_angle,
	output logic                          out_valid,
	output logic signed [uoi_pkg::CW-1:0] out_cos,
	output logic signed [uoi_pkg::CW-1:0] out_sin
);

	logic                  valid_c [uoi_pkg::CORDIC_STAGES+1];
	uoi_pkg::cordic_data_t data_c  [uoi_pkg::CORDIC_STAGES+1];
	uoi_pkg::cordic_data_t entry_d;
	logic [31:0]           angle_sum;
	logic [31:0]           folded;

	// Fold into [-90deg, 90deg) by a half turn, which negates the results.
	always_comb begin
		angle_sum     = in_angle + 32'h4000_0000;
		entry_d.flip  = angle_sum[31];
		folded        = angle_sum[31] ? (in_angle + 32'h8000_0000) : in_angle;
		entry_d.x     = uoi_pkg::GAIN_Q30;
		entry_d.y     = '0;
		entry_d.z     = $signed({{(uoi_pkg::CW-32){folded[31]}}, folded});
	end

	assign valid_c[0] = in_valid;
	assign data_c[0]  = entry_d;

	for (genvar k = 0; k < uoi_pkg::CORDIC_STAGES; k++) begin : g_cell
		uoi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage     (uoi_pkg::ATAN_IDX_W'(k)),
			.in_valid  (valid_c[k]),
			.in_beat   (data_c[k]),
			.out_valid (valid_c[k+1]),
			.out_beat  (data_c[k+1])
		);
	end

	assign out_valid = valid_c[uoi_pkg::CORDIC_STAGES];
	assign out_cos   = data_c[uoi_pkg::CORDIC_STAGES].flip ?
		-data_c[uoi_pkg::CORDIC_STAGES].x : data_c[uoi_pkg::CORDIC_STAGES].x;
	assign out_sin   = data_c[uoi_pkg::CORDIC_STAGES].flip ?
		-data_c[uoi_pkg::CORDIC_STAGES].y : data_c[uoi_pkg::CORDIC_STAGES].y;

endmodule

>>> sv/unicycle_odometry_integrator.sv
// Top level: Euler dead-reckoning pose integrator with CORDIC heading trig.
//
//   channel   dir  handshake                 payload (lowest bit first)
//   s_axis    in   s_axis_tvalid/tready      tdata: lin_vel, ang_vel; tuser: func
//   m_axis    out  m_axis_tvalid/tready      tdata: pos_x, pos_y, heading, quat_z,
//                                            quat_w, lin_vel_echo, ang_vel_echo
//   apb       in   psel & penable & pwrite   register 0 at 0x0: time_step
//
// A velocity command is stored as it is accepted. A tick takes two passes through
// the CORDIC chain, one for the old heading and one for the half of the new heading,
// plus four steps on the shared 32x32 multiplier. One tick is in flight at a time;
// s_axis_tready is high only when the sequencer is idle. The result sits in an
// output register, so a new beat is taken while the previous result still waits;
// a finished tick waits in the last step only if that register is still full.
// Reset clears the pose, the stored velocities and the handshakes and loads
// time_step with 0.1 s.
module unicycle_odometry_integrator (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,	// lin_vel, ang_vel
	input  logic                          s_axis_tuser,	// func
	// result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [159:0]                  m_axis_tdata,	// pos_x, pos_y, heading, quat_z,
								// quat_w, lin_vel_echo, ang_vel_echo
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [uoi_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIG1,
		ST_MUL_X,
		ST_ACC_X,
		ST_ACC_Y,
		ST_ACC_H,
		ST_TURN,
		ST_TRIG2,
		ST_DONE
	} state_t;

	localparam logic signed [63:0] RND38 = 64'sh0000_0020_0000_0000;
	localparam logic signed [63:0] RND16 = 64'sh0000_0000_0000_8000;
	localparam logic signed [32:0] Q15_HALF = 33'sh0_0000_4000;

	state_t              state_q;
	logic [15:0]         time_step_q;
	logic signed [31:0]  x_q;
	logic signed [31:0]  y_q;
	logic [31:0]         heading_q;
	logic signed [15:0]  lin_vel_q;
	logic signed [15:0]  ang_vel_q;

	logic signed [31:0]  vdt_q;
	logic signed [31:0]  wdt_q;
	logic signed [31:0]  c_q;
	logic signed [31:0]  s_q;
	logic signed [63:0]  prod_q;

	logic                in_beat;
	logic                out_free;
	logic                cfg_write;
	logic signed [16:0]  dt_s;
	logic signed [31:0]  vdt_d;
	logic signed [31:0]  wdt_d;
	logic signed [31:0]  mul_a;
	logic signed [31:0]  mul_b;
	logic signed [63:0]  mul_p;
	logic signed [63:0]  dh_d;

	logic                         trig_go;
	logic [31:0]                  trig_angle;
	logic                         trig_valid;
	logic signed [uoi_pkg::CW-1:0] trig_cos;
	logic signed [uoi_pkg::CW-1:0] trig_sin;

	// Round a v*trig*dt product to Q16.16 and add with saturation.
	function automatic logic [31:0] sat_step(input logic [31:0] base,
			input logic signed [63:0] p);
		logic signed [63:0] rnd;
		logic signed [32:0] sum;
		rnd = (p + RND38) >>> 38;
		sum = $signed({base[31], base}) + $signed(rnd[32:0]);
		if (sum[32] != sum[31]) begin
			sat_step = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			sat_step = sum[31:0];
		end
	endfunction

	// Q2.30 to Q1.15 with rounding and saturation.
	function automatic logic [15:0] to_q15(input logic signed [31:0] v);
		logic signed [32:0] r;
		r = ($signed({v[31], v}) + Q15_HALF) >>> 15;
		if ((&r[32:15]) || !(|r[32:15])) begin
			to_q15 = r[15:0];
		end else begin
			to_q15 = r[32] ? 16'h8000 : 16'h7FFF;
		end
	endfunction

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// Configuration port: writes land on the access phase, reads are direct.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[uoi_pkg::ADDR_W-1:2] == uoi_pkg::REG_TIME_STEP) ?
		{16'b0, time_step_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= uoi_pkg::TIME_STEP_RESET;
		end else if (cfg_write && (paddr[uoi_pkg::ADDR_W-1:2] == uoi_pkg::REG_TIME_STEP)) begin
			time_step_q <= pwdata[15:0];
		end
	end

	// Velocity times time step, Q8.8 by Q0.16, exact in 32 bits.
	assign dt_s  = $signed({1'b0, time_step_q});
	assign vdt_d = lin_vel_q * dt_s;
	assign wdt_d = ang_vel_q * dt_s;

	// Shared multiplier: x step, then y step, then heading step.
	always_comb begin
		case (state_q)
			ST_MUL_X: begin
				mul_a = vdt_q;
				mul_b = c_q;
			end
			ST_ACC_X: begin
				mul_a = vdt_q;
				mul_b = s_q;
			end
			default: begin
				mul_a = wdt_q;
				mul_b = uoi_pkg::RAD_TO_BAM_Q16;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign dh_d  = (prod_q + RND16) >>> 16;

	// First pass on the old heading, second pass on half the new heading.
	assign trig_go    = (in_beat && s_axis_tuser) || (state_q == ST_TURN);
	assign trig_angle = (state_q == ST_IDLE) ? heading_q : {1'b0, heading_q[31:1]};

	uoi_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (trig_go),
		.in_angle  (trig_angle),
		.out_valid (trig_valid),
		.out_cos   (trig_cos),
		.out_sin   (trig_sin)
	);

	// Sequencer, pose state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
			x_q           <= '0;
			y_q           <= '0;
			heading_q     <= '0;
			lin_vel_q     <= '0;
			ang_vel_q     <= '0;
		end else begin
			// Raise on a finished tick, drop once the waiting beat is taken.
			if ((state_q == ST_DONE) && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (s_axis_tuser) begin
							state_q <= ST_TRIG1;
						end else begin
							lin_vel_q <= s_axis_tdata[15:0];
							ang_vel_q <= s_axis_tdata[31:16];
						end
					end
				end
				ST_TRIG1: begin
					if (trig_valid) begin
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X: begin
					state_q <= ST_ACC_X;
				end
				ST_ACC_X: begin
					x_q     <= sat_step(x_q, prod_q);
					state_q <= ST_ACC_Y;
				end
				ST_ACC_Y: begin
					y_q     <= sat_step(y_q, prod_q);
					state_q <= ST_ACC_H;
				end
				ST_ACC_H: begin
					heading_q <= heading_q + dh_d[31:0];
					state_q   <= ST_TURN;
				end
				ST_TURN: begin
					state_q <= ST_TRIG2;
				end
				ST_TRIG2: begin
					if (trig_valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold the finished tick until the output register is free.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; magnitudes of the trig results stay below 2^31.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_beat && s_axis_tuser) begin
			vdt_q <= vdt_d;
			wdt_q <= wdt_d;
		end
		if (trig_valid) begin
			c_q <= trig_cos[31:0];
			s_q <= trig_sin[31:0];
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_axis_tdata <= {ang_vel_q, lin_vel_q, to_q15(c_q), to_q15(s_q),
				heading_q, y_q, x_q};
		end
	end

`ifndef SYNTHESIS
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_axis_tuser) |=> !s_axis_tready)
		else $error("tick accepted but input stays ready");

	a_cmd_keeps_pose: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && !s_axis_tuser) |=> ($stable(x_q) && $stable(y_q) && $stable(heading_q)))
		else $error("velocity command moved the pose");

	a_trig_expected: assert property (@(posedge clk) disable iff (!arst_n)
		trig_valid |-> (state_q == ST_TRIG1 || state_q == ST_TRIG2))
		else $error("CORDIC result arrived outside a wait step");

	a_beat_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final step");

	a_heading_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACC_H) |=> $stable(heading_q))
		else $error("heading changed outside its update step");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for the unicycle odometry integrator against a pose predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 48;	// longer than one tick takes, so a trailing tick can finish
	localparam int CYCLE_LIMIT   = 500000;

	// Item kinds carried on tuser.
	localparam logic FUNC_VEL  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Register index just past time_step; writes there must leave the step alone.
	localparam logic [uoi_pkg::ADDR_W-3:0] REG_SPARE = 1'b1;

	// Constants of the fixed-point datapath.
	localparam longint GAIN_Q2_30   = 64'd652032874;
	localparam longint RAD_TO_BAM   = 64'd2670177;
	localparam longint ARCTAN_BAM [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// One input beat waiting to be driven; hold stalls the sender until every
	// pose already due has come back.
	typedef struct {
		logic              func;
		logic [15:0]       lin;
		logic [15:0]       ang;
		bit                hold;
	} cmd_t;

	// One result beat, pos_x in the lowest bits.
	typedef struct packed {
		logic [15:0] ang_echo;
		logic [15:0] lin_echo;
		logic [15:0] quat_w;
		logic [15:0] quat_z;
		logic [31:0] heading;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} pose_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [31:0]         s_axis_tdata = '0;	// lin_vel, ang_vel
	logic                s_axis_tuser = 1'b0;	// func
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [159:0]        m_axis_tdata;	// pos_x, pos_y, heading, quat_z, quat_w,
						// lin_vel_echo, ang_vel_echo
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [uoi_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	// Stimulus waiting for the driver and poses waiting for the result port.
	cmd_t  cmd_q [$];
	pose_t pose_q [$];

	// Predicted state of the integrator.
	logic [15:0]        step_size = uoi_pkg::TIME_STEP_RESET;
	logic signed [31:0] est_x = '0;
	logic signed [31:0] est_y = '0;
	logic [31:0]        est_hdg = '0;
	logic signed [15:0] est_lin = '0;
	logic signed [15:0] est_ang = '0;

	int    mismatches = 0;
	int    cycles = 0;
	bit    steady = 1'b0;	// set to run a stretch without any idling
	bit    loaded = 1'b0;
	cmd_t  cur;
	int    send_gap = 0;
	int    recv_stall = 0;

	// Rotation-mode CORDIC on a binary angle; cos and sin in Q2.30.
	function automatic void cordic_rotate(input logic [31:0] angle, output longint cos_v,
			output longint sin_v);
		logic [31:0] a;
		logic [31:0] probe;
		bit          flip;
		longint      x, y, z, nx;
		int          i;
		a = angle;
		probe = a + 32'h4000_0000;
		flip = probe[31];
		// fold the far half-turn away and negate at the end
		if (flip)
			a = a + 32'h8000_0000;
		z = longint'($signed(a));
		x = GAIN_Q2_30;
		y = 0;
		for (i = 0; i < uoi_pkg::CORDIC_STAGES && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ARCTAN_BAM[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ARCTAN_BAM[i];
			end
			x = nx;
		end
		cos_v = flip ? -x : x;
		sin_v = flip ? -y : y;
	endfunction

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [15:0] round_q15(input longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// Apply one accepted beat to the predicted state; a tick queues the pose it yields.
	task automatic integrate(input cmd_t c);
		longint cs, sn, dt, dx, dy, dh;
		pose_t  p;
		if (c.func == FUNC_VEL) begin
			est_lin = c.lin;
			est_ang = c.ang;
		end else begin
			dt = longint'(step_size);
			// Euler step on the heading from before the step
			cordic_rotate(est_hdg, cs, sn);
			dx = (longint'(est_lin) * cs * dt + (longint'(1) <<< 37)) >>> 38;
			dy = (longint'(est_lin) * sn * dt + (longint'(1) <<< 37)) >>> 38;
			est_x = sat32(longint'(est_x) + dx);
			est_y = sat32(longint'(est_y) + dy);
			dh = (longint'(est_ang) * dt * RAD_TO_BAM + 32768) >>> 16;
			est_hdg = est_hdg + dh[31:0];
			// yaw-only quaternion from half the new heading
			cordic_rotate(est_hdg >> 1, cs, sn);
			p.pos_x    = est_x;
			p.pos_y    = est_y;
			p.heading  = est_hdg;
			p.quat_z   = round_q15(sn);
			p.quat_w   = round_q15(cs);
			p.lin_echo = est_lin;
			p.ang_echo = est_ang;
			pose_q.push_back(p);
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h actual %h", $time, fname, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_item(input logic f, input logic [15:0] lin, input logic [15:0] ang,
			input bit hold);
		cmd_t c;
		c.func = f;
		c.lin  = lin;
		c.ang  = ang;
		c.hold = hold;
		cmd_q.push_back(c);
	endtask

	// A tick carries junk on tdata; the block must not look at it.
	task automatic queue_tick(input bit hold);
		queue_item(FUNC_TICK, 16'($urandom), 16'($urandom), hold);
	endtask

	// Velocity values weighted towards the ends of the range and towards zero.
	function automatic logic [15:0] pick_vel();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 128) - 64);
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly a command followed by a short run of ticks; now and then a bare tick
	// or two commands back to back.
	task automatic queue_random(input int count);
		int made, ticks, kind;
		made = 0;
		while (made < count) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				queue_tick(1'b0);
				made++;
			end else if (kind == 1) begin
				queue_item(FUNC_VEL, pick_vel(), pick_vel(), 1'b0);
				queue_item(FUNC_VEL, pick_vel(), pick_vel(), 1'b0);
				made += 2;
			end else begin
				ticks = $urandom_range(1, 8);
				queue_item(FUNC_VEL, pick_vel(), pick_vel(), $urandom_range(0, 31) == 0);
				repeat (ticks)
					queue_tick(1'b0);
				made += ticks + 1;
			end
		end
	endtask

	// Setup cycle, then access; the register takes the value at the access edge.
	task automatic write_reg(input logic [uoi_pkg::ADDR_W-3:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == uoi_pkg::REG_TIME_STEP)
			step_size = value[15:0];
	endtask

	// Wait until the stream is drained, then give a trailing command time to land.
	task automatic settle();
		while (cmd_q.size() != 0 || loaded || pose_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	unicycle_odometry_integrator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	// Driver: predict on each accepted beat, then load the next one after its gap.
	// tvalid gets exactly one assignment per edge so a back-to-back beat never drops.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				integrate(cur);
				loaded = 1'b0;
			end
			if (!loaded) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_q.size() != 0 && !(cmd_q[0].hold && pose_q.size() != 0)) begin
					cur = cmd_q.pop_front();
					loaded = 1'b1;
					s_axis_tdata <= {cur.ang, cur.lin};
					s_axis_tuser <= cur.func;
					send_gap = steady ? 0 : $urandom_range(0, 3);
				end
			end
			s_axis_tvalid <= loaded;
		end
	end

	// Monitor: compare each result beat with the oldest predicted pose, then hold
	// tready low until a drawn number of cycles with a result waiting have gone by.
	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pose_q.size() == 0) begin
					$display("%0t ns: result with none expected, expected none actual %h",
						$time, m_axis_tdata);
					mismatches++;
				end else begin
					want = pose_q.pop_front();
					check_field("pos_x", want.pos_x, got.pos_x);
					check_field("pos_y", want.pos_y, got.pos_y);
					check_field("heading", want.heading, got.heading);
					check_field("quat_z", want.quat_z, got.quat_z);
					check_field("quat_w", want.quat_w, got.quat_w);
					check_field("lin_vel_echo", want.lin_echo, got.lin_echo);
					check_field("ang_vel_echo", want.ang_echo, got.ang_echo);
				end
				recv_stall = steady ? 0 : $urandom_range(0, 3);
			end else if (m_axis_tvalid && recv_stall > 0) begin
				recv_stall--;
			end
			m_axis_tready <= (recv_stall == 0);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic signed [31:0] delta;
		logic [15:0]        dt_pick [0:4];
		int                 g, ph;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed at the reset step of 0.1 s: a tick before any command, the
		// velocity extremes, a fast spin that wraps the heading, tiny values and
		// two commands back to back (only the second must stick).
		steady = 1'b1;
		queue_tick(1'b0);
		queue_item(FUNC_VEL, 16'h7FFF, 16'h0000, 1'b0);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_item(FUNC_VEL, 16'h8000, 16'h8000, 1'b0);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_item(FUNC_VEL, 16'h7FFF, 16'h7FFF, 1'b0);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_item(FUNC_VEL, 16'h0100, 16'h4000, 1'b0);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_item(FUNC_VEL, 16'h0001, 16'hFFFF, 1'b0);
		queue_tick(1'b0);
		queue_item(FUNC_VEL, 16'hFFFF, 16'h0001, 1'b0);
		queue_item(FUNC_VEL, 16'h0064, 16'hFF38, 1'b0);
		queue_tick(1'b1);	// wait for every pose before this one
		settle();

		// Zero step: the pose must not move, yet every tick still reports.
		write_reg(uoi_pkg::REG_TIME_STEP, {16'($urandom), 16'h0000});
		queue_item(FUNC_VEL, 16'h7FFF, 16'h7FFF, 1'b0);
		queue_tick(1'b0);
		queue_tick(1'b0);
		settle();
		// A write past the last register must be dropped; the step stays zero.
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		queue_tick(1'b0);
		settle();

		// Saturation: longest step, point the heading at 45 degrees, run at full
		// forward speed until both axes clip high, then full reverse until both clip low.
		steady = 1'b0;
		write_reg(uoi_pkg::REG_TIME_STEP, {16'($urandom), 16'hFFFF});
		delta = 32'h2000_0000 - est_hdg;
		queue_item(FUNC_VEL, 16'h0000, 16'((longint'(delta) * 1608) >>> 32), 1'b0);
		queue_tick(1'b0);
		for (g = 0; g < 45; g++) begin
			// small alternating wobble keeps the heading close to the diagonal
			queue_item(FUNC_VEL,
				(g < 15) ? 16'($urandom_range(32512, 32767)) : 16'(32'h8000 + $urandom_range(0, 255)),
				$urandom_range(0, 1) ? 16'h0000 : ((g % 2) ? 16'h0001 : 16'hFFFF), 1'b0);
			repeat (30)
				queue_tick(1'b0);
		end
		settle();

		// Random traffic over a spread of steps, one stretch with no idling at all;
		// finish back on the reset step.
		dt_pick[0] = 16'h0001;
		dt_pick[1] = 16'($urandom);
		dt_pick[2] = 16'h8000;
		dt_pick[3] = 16'($urandom);
		dt_pick[4] = uoi_pkg::TIME_STEP_RESET;
		for (ph = 0; ph < 5; ph++) begin
			steady = (ph == 2);
			write_reg(uoi_pkg::REG_TIME_STEP, {16'($urandom), dt_pick[ph]});
			queue_random(110);
			settle();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> unicycle_odometry_integrator.f
sv/uoi_pkg.sv
sv/uoi_cell.sv
sv/uoi_cordic.sv
sv/unicycle_odometry_integrator.sv
bench/testbench.sv
